>>> rtl/swmt_pkg.sv
package swmt_pkg;

    // Fixed field widths of the stream payloads
    localparam int unsigned FIELD_TIME_W = 48;
    localparam int unsigned CNT_W        = 9;
    localparam int unsigned THR_W        = 9;
    localparam int unsigned WIN_W        = 16;
    localparam int unsigned DT_W         = 24;
    localparam int unsigned IN_TDATA_W   = 48;
    localparam int unsigned OUT_TDATA_W  = 112;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DEADTIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_DEADTIME  = 2'd3;

    // Register reset values
    localparam logic [THR_W-1:0] RST_HIT_THRESHOLD  = 9'd60;
    localparam logic [WIN_W-1:0] RST_WINDOW_LENGTH  = 16'd200;
    localparam logic [DT_W-1:0]  RST_SHORT_DEADTIME = 24'd35000;
    localparam logic [DT_W-1:0]  RST_LONG_DEADTIME  = 24'd535000;

    // Largest reportable hit count
    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK,
        S_WR
    } t_state;

    // Port-width result fields built for one trigger
    typedef struct packed {
        logic [FIELD_TIME_W-1:0] gap;
        logic [CNT_W-1:0]        cnt;
    } t_evt;

endpackage

>>> rtl/swmt_ram.sv
module swmt_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/swmt_evt.sv
module swmt_evt #(
    parameter int unsigned TIME_BITS = 48,
    parameter int unsigned FILL_BITS = 9
) (
    input  logic [TIME_BITS-1:0]        i_start,
    input  logic [FILL_BITS-1:0]        i_fill,
    input  logic                        i_long,
    input  logic [swmt_pkg::DT_W-1:0]   i_long_dt,
    input  logic [swmt_pkg::DT_W-1:0]   i_short_dt,
    input  logic [TIME_BITS-1:0]        i_last_end,
    input  logic                        i_last_valid,
    output logic [TIME_BITS-1:0]        o_end,
    output swmt_pkg::t_evt              o_evt
);

    localparam int unsigned CW = (FILL_BITS > swmt_pkg::CNT_W) ? FILL_BITS : swmt_pkg::CNT_W;

    logic [TIME_BITS:0]   end_sum;
    logic [TIME_BITS-1:0] gap_full;
    logic [CW-1:0]        fill_ext;

    always_comb begin
        // end of event, pinned at the largest time on overflow
        end_sum = {1'b0, i_start}
                + (TIME_BITS+1)'(i_long ? i_long_dt : i_short_dt);
        o_end   = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];

        if (i_last_valid && (i_start >= i_last_end)) begin
            gap_full = i_start - i_last_end;
        end else begin
            gap_full = '1;
        end
        o_evt.gap = swmt_pkg::FIELD_TIME_W'(gap_full);

        fill_ext  = CW'(i_fill);
        o_evt.cnt = (fill_ext > CW'(swmt_pkg::CNT_MAX)) ? swmt_pkg::CNT_MAX
                                                        : swmt_pkg::CNT_W'(fill_ext);
    end

endmodule

>>> rtl/sliding_window_multiplicity_trigger.sv
// Per hit: S_IDLE takes it, issues the head read; S_CHK examines pending starts, one memory
//   read each, until one is open or fires (skipped if none are pending); S_WR may store it.
// A trigger enters the output register once its start is examined and that register is free.
// A hit is taken only in S_IDLE; a trigger waiting on a full output register delays that.
// Reset (i_rst_n low, synchronous): buffer empty, dead time cleared, long dead time
//   armed, registers back to defaults; buffer contents are left as they are.
module sliding_window_multiplicity_trigger #(
    parameter int unsigned BUFFER_DEPTH = 256,
    parameter int unsigned TIME_BITS    = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [swmt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swmt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // hit stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [swmt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [47:0] hit_time
    input  logic                                s_axis_tuser,  // [0] segment_start
    // trigger stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [47:0] trigger_time, [56:48] hit_count, [104:57] gap_since_last, [111:105] zero
    output logic [swmt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser   // [0] is_long
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned FW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned SW = FW + 1;
    localparam int unsigned CW = (FW > swmt_pkg::THR_W) ? FW : swmt_pkg::THR_W;

    // Configuration registers
    logic [swmt_pkg::THR_W-1:0] r_thr;
    logic [swmt_pkg::WIN_W-1:0] r_win;
    logic [swmt_pkg::DT_W-1:0]  r_short_dt;
    logic [swmt_pkg::DT_W-1:0]  r_long_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= swmt_pkg::RST_HIT_THRESHOLD;
            r_win      <= swmt_pkg::RST_WINDOW_LENGTH;
            r_short_dt <= swmt_pkg::RST_SHORT_DEADTIME;
            r_long_dt  <= swmt_pkg::RST_LONG_DEADTIME;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                swmt_pkg::CFG_HIT_THRESHOLD:  r_thr      <= swmt_pkg::THR_W'(i_cfg_wdata);
                swmt_pkg::CFG_WINDOW_LENGTH:  r_win      <= swmt_pkg::WIN_W'(i_cfg_wdata);
                swmt_pkg::CFG_SHORT_DEADTIME: r_short_dt <= i_cfg_wdata;
                swmt_pkg::CFG_LONG_DEADTIME:  r_long_dt  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer state
    swmt_pkg::t_state     r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [FW-1:0]        r_fill, n_fill;
    logic [TIME_BITS-1:0] r_dead, n_dead;
    logic [TIME_BITS-1:0] r_last_end, n_last_end;
    logic                 r_last_valid, n_last_valid;
    logic                 r_long, n_long;
    logic [TIME_BITS-1:0] r_t, n_t;          // hit under work

    // Output register
    logic                                 r_ovalid, n_ovalid;
    logic [swmt_pkg::FIELD_TIME_W-1:0]    r_otime, n_otime;
    logic                                 r_olong, n_olong;
    swmt_pkg::t_evt                       r_oevt, n_oevt;

    // Start buffer access
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [AW-1:0]        ram_rd_addr;
    logic [TIME_BITS-1:0] ram_rd_data;

    swmt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_t),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Trigger fields for the start at the head of the buffer
    logic [TIME_BITS-1:0] evt_end;
    swmt_pkg::t_evt       evt;

    swmt_evt #(
        .TIME_BITS (TIME_BITS),
        .FILL_BITS (FW)
    ) u_evt (
        .i_start      (ram_rd_data),
        .i_fill       (r_fill),
        .i_long       (r_long),
        .i_long_dt    (r_long_dt),
        .i_short_dt   (r_short_dt),
        .i_last_end   (r_last_end),
        .i_last_valid (r_last_valid),
        .o_end        (evt_end),
        .o_evt        (evt)
    );

    logic                 in_xfer;
    logic                 out_free;
    logic                 win_closed;
    logic                 fire;
    logic [TIME_BITS-1:0] age;
    logic [AW-1:0]        head_next;
    logic [SW-1:0]        tail_sum;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        // window of the head start is closed once the hit lies window_length past it
        age        = r_t - ram_rd_data;
        win_closed = (r_t >= ram_rd_data) && (age >= TIME_BITS'(r_win));
        fire       = CW'(r_fill) >= CW'(r_thr);
        head_next  = (r_head == AW'(BUFFER_DEPTH - 1)) ? '0 : r_head + 1'b1;

        // ring slot after the newest start
        tail_sum = SW'(r_head) + SW'(r_fill);
        if (tail_sum >= SW'(BUFFER_DEPTH)) begin
            tail_sum = tail_sum - SW'(BUFFER_DEPTH);
        end
        ram_wr_addr = AW'(tail_sum);
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_dead       = r_dead;
        n_last_end   = r_last_end;
        n_last_valid = r_last_valid;
        n_long       = r_long;
        n_t          = r_t;
        n_ovalid     = r_ovalid && !m_axis_tready;
        n_otime      = r_otime;
        n_olong      = r_olong;
        n_oevt       = r_oevt;
        ram_wr_en    = 1'b0;
        ram_rd_addr  = r_head;
        s_axis_tready = 1'b0;

        case (r_state)
            swmt_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_xfer) begin
                    n_t    = TIME_BITS'(s_axis_tdata);
                    n_long = r_long | s_axis_tuser;   // re-arm before this hit
                    // head read issued now, data seen in S_CHK
                    n_state = (r_fill != '0) ? swmt_pkg::S_CHK : swmt_pkg::S_WR;
                end
            end
            swmt_pkg::S_CHK: begin
                if (!win_closed) begin
                    n_state = swmt_pkg::S_WR;
                end else if (fire) begin
                    // hold here until the output register can take the trigger
                    if (out_free) begin
                        n_ovalid     = 1'b1;
                        n_otime      = swmt_pkg::FIELD_TIME_W'(ram_rd_data);
                        n_olong      = r_long;
                        n_oevt       = evt;
                        n_dead       = evt_end;
                        n_last_end   = evt_end;
                        n_last_valid = 1'b1;
                        n_long       = 1'b0;
                        n_head       = '0;
                        n_fill       = '0;
                        n_state      = swmt_pkg::S_WR;
                    end
                end else begin
                    // retire the head start, fetch the next one
                    n_head      = head_next;
                    n_fill      = r_fill - 1'b1;
                    ram_rd_addr = head_next;
                    if (r_fill == FW'(1)) begin
                        n_state = swmt_pkg::S_WR;
                    end
                end
            end
            swmt_pkg::S_WR: begin
                if ((r_t >= r_dead) && (r_fill < FW'(BUFFER_DEPTH))) begin
                    ram_wr_en = 1'b1;
                    n_fill    = r_fill + 1'b1;
                end
                n_state = swmt_pkg::S_IDLE;
            end
            default: begin
                n_state = swmt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= swmt_pkg::S_IDLE;
            r_head       <= '0;
            r_fill       <= '0;
            r_dead       <= '0;
            r_last_end   <= '0;
            r_last_valid <= 1'b0;
            r_long       <= 1'b1;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_fill       <= n_fill;
            r_dead       <= n_dead;
            r_last_end   <= n_last_end;
            r_last_valid <= n_last_valid;
            r_long       <= n_long;
            r_ovalid     <= n_ovalid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_otime <= n_otime;
        r_olong <= n_olong;
        r_oevt  <= n_oevt;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_olong;
    assign m_axis_tdata  = {7'b0, r_oevt.gap, r_oevt.cnt, r_otime};

endmodule

>>> sim/sliding_window_multiplicity_trigger_checker.sv
`timescale 1ns / 1ps

module sliding_window_multiplicity_trigger_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [swmt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swmt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_hit_valid,
    input  logic                                i_hit_ready,
    input  logic [swmt_pkg::IN_TDATA_W-1:0]     i_hit_data,   // [47:0] hit_time
    input  logic                                i_hit_user,   // [0] segment_start
    input  logic                                i_trig_valid,
    input  logic                                i_trig_ready,
    // [47:0] trigger_time, [56:48] hit_count, [104:57] gap_since_last, [111:105] zero
    input  logic [swmt_pkg::OUT_TDATA_W-1:0]    i_trig_data,
    input  logic                                i_trig_user,  // [0] is_long
    output int                                  o_fail_count,
    output int                                  o_due_count,
    output int                                  o_trig_count,
    output int                                  o_long_count
);

    localparam int unsigned TW         = swmt_pkg::FIELD_TIME_W;
    localparam logic [TW-1:0] TIME_MAX = '1;
    localparam int unsigned RING_DEPTH = 256;
    localparam int          REPORT_CAP = 100;

    typedef struct {
        logic [TW-1:0]                start_time;
        logic                         is_long;
        logic [swmt_pkg::CNT_W-1:0]   hits;
        logic [TW-1:0]                gap;
    } t_trig;

    t_trig                   due_triggers[$];

    // window starts still open, oldest at ring_head
    logic [TW-1:0]              start_ring [0:RING_DEPTH-1];
    logic [7:0]                 ring_head;
    logic [swmt_pkg::CNT_W-1:0] ring_fill;
    logic [TW-1:0]              dead_end;
    logic [TW-1:0]              prev_end;
    logic                       prev_end_ok;
    logic                       long_armed_q;

    logic [swmt_pkg::THR_W-1:0] thr_q;
    logic [swmt_pkg::WIN_W-1:0] win_q;
    logic [swmt_pkg::DT_W-1:0]  short_dt_q;
    logic [swmt_pkg::DT_W-1:0]  long_dt_q;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < REPORT_CAP) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic clear_state();
        due_triggers.delete();
        ring_head    = '0;
        ring_fill    = '0;
        dead_end     = '0;
        prev_end     = '0;
        prev_end_ok  = 1'b0;
        long_armed_q = 1'b1;
        thr_q        = swmt_pkg::RST_HIT_THRESHOLD;
        win_q        = swmt_pkg::RST_WINDOW_LENGTH;
        short_dt_q   = swmt_pkg::RST_SHORT_DEADTIME;
        long_dt_q    = swmt_pkg::RST_LONG_DEADTIME;
        o_fail_count = 0;
        o_trig_count = 0;
        o_long_count = 0;
    endtask

    task automatic load_register();
        case (i_cfg_index)
            swmt_pkg::CFG_HIT_THRESHOLD:  thr_q      = i_cfg_wdata[swmt_pkg::THR_W-1:0];
            swmt_pkg::CFG_WINDOW_LENGTH:  win_q      = i_cfg_wdata[swmt_pkg::WIN_W-1:0];
            swmt_pkg::CFG_SHORT_DEADTIME: short_dt_q = i_cfg_wdata[swmt_pkg::DT_W-1:0];
            swmt_pkg::CFG_LONG_DEADTIME:  long_dt_q  = i_cfg_wdata[swmt_pkg::DT_W-1:0];
            default: ;
        endcase
    endtask

    // One hit: close windows from the oldest start, fire at most once, then
    // keep the hit as a new start if it lies outside the dead time and the ring has room.
    task automatic advance_window(input logic [TW-1:0] t, input logic seg);
        logic [TW-1:0] s;
        logic [TW-1:0] dt;
        logic [TW-1:0] ev_end;
        logic [7:0]    slot;
        t_trig         trig;
        bit            closed;
        if (seg) long_armed_q = 1'b1;
        closed = 1'b0;
        while (ring_fill != 0 && !closed) begin
            s = start_ring[ring_head];
            if (t < s || (t - s) < TW'(win_q)) begin
                closed = 1'b1;
            end else if (ring_fill >= thr_q) begin
                dt     = long_armed_q ? TW'(long_dt_q) : TW'(short_dt_q);
                ev_end = (TIME_MAX - s < dt) ? TIME_MAX : s + dt;
                trig.start_time = s;
                trig.is_long    = long_armed_q;
                trig.hits       = ring_fill;
                trig.gap        = (prev_end_ok && s >= prev_end) ? s - prev_end : TIME_MAX;
                due_triggers.insert(due_triggers.size(), trig);
                if (long_armed_q) o_long_count++;
                dead_end     = ev_end;
                prev_end     = ev_end;
                prev_end_ok  = 1'b1;
                long_armed_q = 1'b0;
                ring_head    = '0;
                ring_fill    = '0;
                closed       = 1'b1;
            end else begin
                ring_head = ring_head + 8'd1;
                ring_fill = ring_fill - 9'd1;
            end
        end
        if (t >= dead_end && ring_fill < swmt_pkg::CNT_W'(RING_DEPTH)) begin
            slot             = ring_head + ring_fill[7:0];
            start_ring[slot] = t;
            ring_fill        = ring_fill + 9'd1;
        end
    endtask

    task automatic check_trigger();
        t_trig                      want;
        logic [TW-1:0]              got_start;
        logic [TW-1:0]              got_gap;
        logic [swmt_pkg::CNT_W-1:0] got_hits;
        logic [6:0]                 got_pad;
        got_start = i_trig_data[47:0];
        got_hits  = i_trig_data[56:48];
        got_gap   = i_trig_data[104:57];
        got_pad   = i_trig_data[111:105];
        o_trig_count++;
        if (due_triggers.size() == 0) begin
            report_mismatch($sformatf("trigger t=%0d with nothing due", got_start));
        end else begin
            want = due_triggers.pop_front();
            if (got_start !== want.start_time || i_trig_user !== want.is_long ||
                got_hits !== want.hits || got_gap !== want.gap || got_pad !== 7'd0) begin
                report_mismatch($sformatf(
                    "got t=%0d long=%b n=%0d gap=%h pad=%h, want t=%0d long=%b n=%0d gap=%h",
                    got_start, i_trig_user, got_hits, got_gap, got_pad,
                    want.start_time, want.is_long, want.hits, want.gap));
            end
        end
    endtask

    // output side first: a trigger can never stem from a hit of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_trig_valid && i_trig_ready) check_trigger();
            if (i_cfg_wr_en) load_register();
            if (i_hit_valid && i_hit_ready) advance_window(i_hit_data[47:0], i_hit_user);
        end
        o_due_count = due_triggers.size();
    end

endmodule

>>> sim/sliding_window_multiplicity_trigger_tb.sv
`timescale 1ns / 1ps

module sliding_window_multiplicity_trigger_tb;

    localparam logic [47:0] TIME_MAX        = '1;
    // idle time before a register write: covers a hit retiring a full buffer
    localparam int          DRAIN_CYCLES    = 300;
    // receiver hold-off long enough for the output register to fill and block input
    localparam int          HOLD_OFF_CYCLES = 400;
    // cycles without any transfer before the run is declared hung
    localparam int          STALL_LIMIT     = 20000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_wr_en;
    logic [swmt_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [swmt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [swmt_pkg::IN_TDATA_W-1:0]     s_axis_tdata;   // [47:0] hit_time
    logic                                s_axis_tuser;   // [0] segment_start
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // [47:0] trigger_time, [56:48] hit_count, [104:57] gap_since_last, [111:105] zero
    logic [swmt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                                m_axis_tuser;   // [0] is_long

    int fail_count;
    int due_count;
    int trig_count;
    int long_count;

    // stimulus bookkeeping
    logic [47:0]                tnow;     // running hit time, nondecreasing apart from steps back
    logic [swmt_pkg::THR_W-1:0] cur_thr;
    logic [swmt_pkg::WIN_W-1:0] cur_win;
    logic [swmt_pkg::DT_W-1:0]  cur_sdt;
    logic [swmt_pkg::DT_W-1:0]  cur_ldt;
    int                         hits_sent;
    int                         settings_done;
    int                         idle_cycles;
    bit                         quiet;         // no idling on either side while set
    bit                         hold_off_req;  // asks the receiver for one long hold-off

    sliding_window_multiplicity_trigger dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sliding_window_multiplicity_trigger_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_hit_valid  (s_axis_tvalid),
        .i_hit_ready  (s_axis_tready),
        .i_hit_data   (s_axis_tdata),
        .i_hit_user   (s_axis_tuser),
        .i_trig_valid (m_axis_tvalid),
        .i_trig_ready (m_axis_tready),
        .i_trig_data  (m_axis_tdata),
        .i_trig_user  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_due_count  (due_count),
        .o_trig_count (trig_count),
        .o_long_count (long_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_wr_en || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d cycles without a transfer, %0d triggers outstanding",
                     idle_cycles, due_count);
            $display("[sliding_window_multiplicity_trigger] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 12);
            end
        end
    end

    // Offer one hit; returns just after the edge at which it is transferred.
    task automatic send_hit(input logic [47:0] t, input logic seg);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        s_axis_tuser  <= seg;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hits_sent++;
    endtask

    task automatic step_hit(input logic [47:0] inc, input logic seg);
        tnow = tnow + inc;
        send_hit(tnow, seg);
    endtask

    // Block idle: no transfer offered, nothing due, and time for a last
    // hit that fires nothing to finish retiring its starts.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [swmt_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [swmt_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [swmt_pkg::THR_W-1:0] thr,
                              input logic [swmt_pkg::WIN_W-1:0] win,
                              input logic [swmt_pkg::DT_W-1:0]  sdt,
                              input logic [swmt_pkg::DT_W-1:0]  ldt);
        settle();
        cfg_write(swmt_pkg::CFG_HIT_THRESHOLD,  swmt_pkg::CFG_DATA_W'(thr));
        cfg_write(swmt_pkg::CFG_WINDOW_LENGTH,  swmt_pkg::CFG_DATA_W'(win));
        cfg_write(swmt_pkg::CFG_SHORT_DEADTIME, sdt);
        cfg_write(swmt_pkg::CFG_LONG_DEADTIME,  ldt);
        cur_thr = thr;
        cur_win = win;
        cur_sdt = sdt;
        cur_ldt = ldt;
        settings_done++;
    endtask

    // Short windows and dead times, so that clusters fire often; the short
    // dead time is frequently below the window length.
    task automatic random_config();
        logic [swmt_pkg::WIN_W-1:0] w;
        logic [swmt_pkg::DT_W-1:0]  s;
        w = swmt_pkg::WIN_W'($urandom_range(20, 2000));
        s = swmt_pkg::DT_W'($urandom_range(1, 5000));
        set_config(swmt_pkg::THR_W'($urandom_range(1, 8)), w, s,
                   swmt_pkg::DT_W'(32'(s) + $urandom_range(0, 60000)));
    endtask

    // Mostly hit clusters sized around the threshold and packed inside one
    // window, separated by jumps that land inside or past the dead times;
    // the rest is lone noise hits, steps back in time and segment marks.
    task automatic random_phase(input int n_items);
        int          sent;
        int          m;
        int          r;
        logic [47:0] jump;
        logic [47:0] back;
        sent = 0;
        while (sent < n_items) begin
            r = int'($urandom_range(99));
            if (r < 65) begin
                m = int'(cur_thr) + int'($urandom_range(0, 3));
                if ($urandom_range(9) == 0) m = m - 2;
                if (m < 1) m = 1;
                case ($urandom_range(2))
                    0: jump = 48'(cur_win) + 48'($urandom_range(0, cur_win));
                    1: jump = 48'(cur_sdt) + 48'($urandom_range(0, cur_win));
                    default: jump = 48'(cur_ldt) + 48'($urandom_range(0, cur_win));
                endcase
                step_hit(jump, $urandom_range(4) == 0);
                for (int i = 1; i < m; i++) begin
                    step_hit(48'($urandom_range(0, int'(cur_win) / m)),
                             $urandom_range(19) == 0);
                end
                sent += m;
            end else if (r < 85) begin
                step_hit(48'($urandom_range(0, 3 * int'(cur_win))), $urandom_range(19) == 0);
                sent++;
            end else if (r < 93) begin
                back = 48'($urandom_range(1, int'(cur_win) + 1));
                if (tnow > back) send_hit(tnow - back, $urandom_range(3) == 0);
                sent++;
            end else begin
                step_hit(48'(cur_ldt) + 48'($urandom_range(0, cur_win)), 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        hits_sent     = 0;
        settings_done = 0;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        tnow          = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: small threshold and window ---
        set_config(9'd3, 16'd100, 24'd500, 24'd2000);
        send_hit(48'd0, 1'b1);       // lowest time, segment mark
        send_hit(48'd10, 1'b0);
        send_hit(48'd20, 1'b0);
        send_hit(48'd99, 1'b0);      // still inside the first window
        send_hit(48'd100, 1'b0);     // closes it on the boundary: first trigger, long, no gap
        send_hit(48'd1999, 1'b0);    // inside the long dead time
        send_hit(48'd2000, 1'b0);    // exactly at its end: new start
        send_hit(48'd2050, 1'b0);
        send_hit(48'd2050, 1'b0);    // equal time stamps
        send_hit(48'd2040, 1'b0);    // step back, still past the dead time
        send_hit(48'd2100, 1'b0);    // short trigger, zero gap
        send_hit(48'd2600, 1'b0);
        send_hit(48'd2700, 1'b0);    // window below threshold is retired
        send_hit(48'd2800, 1'b0);
        send_hit(48'd2810, 1'b1);    // segment mark re-arms the long dead time
        send_hit(48'd2820, 1'b0);
        send_hit(48'd2900, 1'b0);    // long trigger again

        // zero threshold, zero window, zero dead times
        set_config(9'd0, 16'd0, 24'd0, 24'd0);
        send_hit(48'd5000, 1'b0);
        send_hit(48'd5000, 1'b0);    // closes the previous hit's start at once
        send_hit(48'd4999, 1'b0);    // behind the dead time end: dropped
        send_hit(48'd5001, 1'b0);
        tnow = 48'd5001;

        // --- buffer overflow: more starts than entries inside one wide window ---
        set_config(9'd256, 16'hFFFF, 24'd1000, 24'd1000);
        step_hit(48'd20_000_000, 1'b0);
        for (int i = 1; i < 270; i++) begin
            step_hit(48'($urandom_range(0, 200)), $urandom_range(19) == 0);
        end
        step_hit(48'd65535, 1'b0);   // fires with the buffer full, count 256
        set_config(9'd511, 16'hFFFF, 24'd1000, 24'd1000);
        step_hit(48'd70_000, 1'b0);
        for (int i = 1; i < 40; i++) step_hit(48'($urandom_range(0, 200)), 1'b0);
        step_hit(48'd70_000, 1'b0);  // retires every start in one go, none fires

        // --- random phases ---
        random_config();
        random_phase(150);

        quiet = 1'b1;
        random_config();
        random_phase(150);
        quiet = 1'b0;

        // receiver holds off while clusters keep firing
        set_config(9'd1, swmt_pkg::WIN_W'($urandom_range(50, 500)),
                   swmt_pkg::DT_W'($urandom_range(1, 400)),
                   swmt_pkg::DT_W'($urandom_range(400, 3000)));
        hold_off_req = 1'b1;
        random_phase(150);

        set_config(swmt_pkg::THR_W'($urandom_range(1, 4)), 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_phase(100);

        // move well up the time range to exercise the upper time bits
        settle();
        tnow = tnow + 48'h4000_0000_0000 + {16'h0, 32'($urandom)};
        random_config();
        random_phase(150);

        random_config();
        random_phase(150);

        // --- top of the time range: event end saturates ---
        set_config(9'd2, 16'd100, 24'hFFFFFF, 24'hFFFFFF);
        tnow = TIME_MAX - 48'd5000;
        send_hit(tnow, 1'b1);
        step_hit(48'd10, 1'b0);
        step_hit(48'd20, 1'b0);
        step_hit(48'd200, 1'b0);     // long trigger, end clipped at the largest time
        send_hit(TIME_MAX - 48'd1, 1'b0);
        send_hit(TIME_MAX, 1'b0);
        send_hit(TIME_MAX, 1'b1);

        // drain and let any late result show itself
        settle();

        $display("covered %0d hits over %0d register settings, %0d triggers checked (%0d long)",
                 hits_sent, settings_done, trig_count, long_count);
        $display("including buffer overflow, zero threshold and window, time range top");
        if (fail_count == 0) begin
            $display("[sliding_window_multiplicity_trigger] OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[sliding_window_multiplicity_trigger] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/swmt_pkg.sv
rtl/swmt_ram.sv
rtl/swmt_evt.sv
rtl/sliding_window_multiplicity_trigger.sv
sim/sliding_window_multiplicity_trigger_checker.sv
sim/sliding_window_multiplicity_trigger_tb.sv
